// ----- rtl/core/skhm_pkg.sv -----
// Shared types and constants of the string-key hash map core.
// No dependencies; imported by every module of the core.
package skhm_pkg;

    localparam int TABLE_SLOTS_DEF = 16;
    localparam int KEY_BYTES_DEF   = 33;
    localparam int VALUE_BYTES_DEF = 64;
    localparam int QUEUE_DEPTH     = 4;
    localparam logic [31:0] HASH_SEED = 32'd5381;

    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_GET   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_REFUSED  = 3'd1;
    localparam logic [2:0] ST_VALUE    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] text_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] value_byte;
        logic       last_result;
    } out_item_t;

    // Work classified by the front end for the back end
    typedef enum logic [2:0] {
        OP_CLEAR   = 3'd0,
        OP_KEY     = 3'd1,
        OP_END_GET = 3'd2,
        OP_END_PUT = 3'd3,
        OP_VAL     = 3'd4,
        OP_VAL_END = 3'd5
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       first;
        logic [7:0] data;
    } cmd_t;

endpackage

// ----- rtl/core/skhm_front.sv -----
// Front end: accepts input beats, tracks the request phase, emits commands.
// Depends on skhm_pkg.
module skhm_front
    import skhm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     push,
    output cmd_t     push_cmd,
    input  logic     push_ready
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_KEY   = 3'b010,
        PH_VALUE = 3'b100
    } phase_t;

    phase_t phase_reg, phase_next;
    logic   is_put_reg, is_put_next;
    logic   take;
    logic   put_now;

    assign s_ready = push_ready;
    assign take    = s_valid && push_ready;
    assign put_now = (phase_reg == PH_IDLE) ? (s_data.req_type == REQ_PUT) : is_put_reg;

    always_comb begin
        phase_next     = phase_reg;
        is_put_next    = is_put_reg;
        push           = 1'b0;
        push_cmd.op    = OP_KEY;
        push_cmd.first = 1'b0;
        push_cmd.data  = s_data.text_byte;
        if (take) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (s_data.req_type == REQ_CLEAR) begin
                        push        = 1'b1;
                        push_cmd.op = OP_CLEAR;
                    end else if (s_data.req_type == REQ_PUT || s_data.req_type == REQ_GET) begin
                        push           = 1'b1;
                        push_cmd.first = 1'b1;
                        is_put_next    = put_now;
                        if (s_data.text_byte != 8'd0) begin
                            push_cmd.op = OP_KEY;
                            phase_next  = PH_KEY;
                        end else begin
                            push_cmd.op = put_now ? OP_END_PUT : OP_END_GET;
                            phase_next  = put_now ? PH_VALUE : PH_IDLE;
                        end
                    end
                end
                PH_KEY: begin
                    push = 1'b1;
                    if (s_data.text_byte != 8'd0) begin
                        push_cmd.op = OP_KEY;
                    end else begin
                        push_cmd.op = put_now ? OP_END_PUT : OP_END_GET;
                        phase_next  = put_now ? PH_VALUE : PH_IDLE;
                    end
                end
                PH_VALUE: begin
                    push = 1'b1;
                    if (s_data.text_byte != 8'd0) begin
                        push_cmd.op = OP_VAL;
                    end else begin
                        push_cmd.op = OP_VAL_END;
                        phase_next  = PH_IDLE;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            is_put_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            is_put_reg <= is_put_next;
        end
    end

endmodule

// ----- rtl/core/skhm_queue.sv -----
// Short command queue between front and back end.
// Depends on skhm_pkg.
module skhm_queue
    import skhm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic push_ready,
    output logic pop_valid,
    output cmd_t pop_cmd,
    input  logic pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          do_push, do_pop;

    assign push_ready = (fill_reg != CW'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = entry_reg[rd_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_next   = do_push ? ((wr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next   = do_pop  ? ((rd_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1) : rd_reg;
        fill_next = fill_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end else begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ----- rtl/core/skhm_back.sv -----
// Back end: hashing, probing, key and value stores, result register.
// Depends on skhm_pkg.
module skhm_back
    import skhm_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int KEY_BYTES   = KEY_BYTES_DEF,
    parameter int VALUE_BYTES = VALUE_BYTES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    input  cmd_t      q_cmd,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int SW  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int IW  = $clog2(TABLE_SLOTS + 1);
    localparam int CW  = $clog2(TABLE_SLOTS + 1);
    localparam int KLW = $clog2(KEY_BYTES);
    localparam int VIW = $clog2(VALUE_BYTES);
    localparam int KAW = $clog2(TABLE_SLOTS * KEY_BYTES);
    localparam int VAW = $clog2(TABLE_SLOTS * VALUE_BYTES);
    // Rounded-up reciprocal of the slot count, exact quotient for any 32-bit hash
    localparam int          HL   = $clog2(TABLE_SLOTS);
    localparam logic [63:0] HPOW = 64'd1 << (32 + HL);
    localparam logic [32:0] HMUL =
        33'((HPOW + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS));

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_HMUL  = 11'b00000000010,
        S_HRED  = 11'b00000000100,
        S_PCHK  = 11'b00000001000,
        S_CMPA  = 11'b00000010000,
        S_CMPB  = 11'b00000100000,
        S_VALA  = 11'b00001000000,
        S_VALB  = 11'b00010000000,
        S_COPYA = 11'b00100000000,
        S_COPYB = 11'b01000000000,
        S_EMIT  = 11'b10000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [31:0]      hash_reg, hash_next;
    logic [KLW-1:0]   klen_reg, klen_next;
    logic             long_reg, long_next;
    logic             get_reg, get_next;
    logic [31:0]      quo_reg, quo_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic [IW-1:0]    tries_reg, tries_next;
    logic [KLW-1:0]   kidx_reg, kidx_next;
    logic [VIW-1:0]   vidx_reg, vidx_next;
    logic             refused_reg, refused_next;
    logic             fresh_reg, fresh_next;
    logic [TABLE_SLOTS-1:0] used_reg, used_next;
    logic [CW-1:0]    count_reg, count_next;
    out_item_t        res_reg, res_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    logic [7:0] kbuf_mem [KEY_BYTES];
    logic [7:0] kst_mem  [TABLE_SLOTS * KEY_BYTES];
    logic [7:0] val_mem  [TABLE_SLOTS * VALUE_BYTES];
    logic [7:0] kbuf_rd_reg, kst_rd_reg, val_rd_reg;

    logic           kb_we;
    logic [KLW-1:0] kb_wa;
    logic           ks_we;
    logic [KAW-1:0] ks_wa;
    logic [7:0]     ks_wd;
    logic           vs_we;
    logic [VAW-1:0] vs_wa;
    logic [7:0]     vs_wd;
    logic [KAW-1:0] ks_ra;
    logic [VAW-1:0] vs_ra;

    logic           out_free;
    logic [31:0]    base_hash;
    logic [KLW-1:0] base_len;
    logic           base_long;
    logic [64:0]    hprod;
    logic [31:0]    hrem;
    logic [SW-1:0]  slot_inc;
    logic [7:0]     kbuf_byte;

    assign out_free  = !m_valid_reg || m_ready;
    assign base_hash = q_cmd.first ? HASH_SEED : hash_reg;
    assign base_len  = q_cmd.first ? '0 : klen_reg;
    assign base_long = q_cmd.first ? 1'b0 : long_reg;
    assign hprod     = 65'(hash_reg) * 65'(HMUL);
    assign hrem      = hash_reg - 32'(quo_reg * 32'(TABLE_SLOTS));
    assign slot_inc  = (slot_reg == SW'(TABLE_SLOTS - 1)) ? '0 : slot_reg + 1'b1;
    // The terminator sits past the last kept key byte
    assign kbuf_byte = (kidx_reg == klen_reg) ? 8'd0 : kbuf_rd_reg;
    assign ks_ra     = KAW'(slot_reg) * KAW'(KEY_BYTES) + KAW'(kidx_reg);
    assign vs_ra     = VAW'(slot_reg) * VAW'(VALUE_BYTES) + VAW'(vidx_reg);

    always_comb begin
        state_next   = state_reg;
        hash_next    = hash_reg;
        klen_next    = klen_reg;
        long_next    = long_reg;
        get_next     = get_reg;
        quo_next     = quo_reg;
        slot_next    = slot_reg;
        tries_next   = tries_reg;
        kidx_next    = kidx_reg;
        vidx_next    = vidx_reg;
        refused_next = refused_reg;
        fresh_next   = fresh_reg;
        used_next    = used_reg;
        count_next   = count_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        q_pop        = 1'b0;
        kb_we        = 1'b0;
        kb_wa        = base_len;
        ks_we        = 1'b0;
        ks_wa        = ks_ra;
        ks_wd        = kbuf_byte;
        vs_we        = 1'b0;
        vs_wa        = vs_ra;
        vs_wd        = q_cmd.data;

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    case (q_cmd.op)
                        OP_CLEAR: begin
                            used_next  = '0;
                            count_next = '0;
                            res_next   = '{ST_CLEARED, 8'd0, 1'b1};
                            state_next = S_EMIT;
                        end
                        OP_KEY: begin
                            hash_next = (base_hash << 5) + base_hash + {24'd0, q_cmd.data};
                            if (base_len < KLW'(KEY_BYTES - 1)) begin
                                kb_we     = 1'b1;
                                klen_next = base_len + 1'b1;
                                long_next = base_long;
                            end else begin
                                klen_next = base_len;
                                long_next = 1'b1;
                            end
                        end
                        OP_END_GET, OP_END_PUT: begin
                            hash_next = base_hash;
                            klen_next = base_len;
                            long_next = base_long;
                            get_next  = (q_cmd.op == OP_END_GET);
                            vidx_next = '0;
                            if (q_cmd.op == OP_END_PUT && count_reg >= CW'(TABLE_SLOTS)) begin
                                refused_next = 1'b1;
                                fresh_next   = 1'b0;
                            end else begin
                                state_next = S_HMUL;
                            end
                        end
                        OP_VAL: begin
                            if (!refused_reg && vidx_reg != VIW'(VALUE_BYTES - 1)) begin
                                vs_we     = 1'b1;
                                vidx_next = vidx_reg + 1'b1;
                            end
                        end
                        OP_VAL_END: begin
                            if (refused_reg) begin
                                res_next   = '{ST_REFUSED, 8'd0, 1'b1};
                                state_next = S_EMIT;
                            end else begin
                                vs_we = 1'b1;
                                vs_wd = 8'd0;
                                if (fresh_reg) begin
                                    kidx_next  = '0;
                                    state_next = S_COPYA;
                                end else begin
                                    res_next   = '{ST_STORED, 8'd0, 1'b1};
                                    state_next = S_EMIT;
                                end
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_HMUL: begin
                // Quotient of the hash by the slot count
                quo_next   = 32'(hprod >> (32 + HL));
                state_next = S_HRED;
            end
            S_HRED: begin
                slot_next  = SW'(hrem);
                tries_next = '0;
                state_next = S_PCHK;
            end
            S_PCHK: begin
                kidx_next = '0;
                if (tries_reg == IW'(TABLE_SLOTS) || !used_reg[slot_reg]) begin
                    if (get_reg) begin
                        res_next   = '{ST_NOTFOUND, 8'd0, 1'b1};
                        state_next = S_EMIT;
                    end else begin
                        refused_next = (tries_reg == IW'(TABLE_SLOTS));
                        fresh_next   = 1'b1;
                        state_next   = S_IDLE;
                    end
                end else if (long_reg) begin
                    tries_next = tries_reg + 1'b1;
                    slot_next  = slot_inc;
                end else begin
                    state_next = S_CMPA;
                end
            end
            S_CMPA: begin
                state_next = S_CMPB;
            end
            S_CMPB: begin
                if (kst_rd_reg != kbuf_byte) begin
                    tries_next = tries_reg + 1'b1;
                    slot_next  = slot_inc;
                    state_next = S_PCHK;
                end else if (kidx_reg == klen_reg) begin
                    vidx_next = '0;
                    if (get_reg) begin
                        state_next = S_VALA;
                    end else begin
                        refused_next = 1'b0;
                        fresh_next   = 1'b0;
                        state_next   = S_IDLE;
                    end
                end else begin
                    kidx_next  = kidx_reg + 1'b1;
                    state_next = S_CMPA;
                end
            end
            S_VALA: begin
                state_next = S_VALB;
            end
            S_VALB: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (val_rd_reg == 8'd0 || vidx_reg == VIW'(VALUE_BYTES - 1)) begin
                        m_data_next = '{ST_VALUE, 8'd0, 1'b1};
                        state_next  = S_IDLE;
                    end else begin
                        m_data_next = '{ST_VALUE, val_rd_reg, 1'b0};
                        vidx_next   = vidx_reg + 1'b1;
                        state_next  = S_VALA;
                    end
                end
            end
            S_COPYA: begin
                state_next = S_COPYB;
            end
            S_COPYB: begin
                ks_we = 1'b1;
                if (kidx_reg == klen_reg) begin
                    used_next[slot_reg] = 1'b1;
                    count_next = count_reg + 1'b1;
                    res_next   = '{ST_STORED, 8'd0, 1'b1};
                    state_next = S_EMIT;
                end else begin
                    kidx_next  = kidx_reg + 1'b1;
                    state_next = S_COPYA;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (kb_we) begin
            kbuf_mem[kb_wa] <= q_cmd.data;
        end
        kbuf_rd_reg <= kbuf_mem[kidx_reg];
    end

    always_ff @(posedge aclk) begin
        if (ks_we) begin
            kst_mem[ks_wa] <= ks_wd;
        end
        kst_rd_reg <= kst_mem[ks_ra];
    end

    always_ff @(posedge aclk) begin
        if (vs_we) begin
            val_mem[vs_wa] <= vs_wd;
        end
        val_rd_reg <= val_mem[vs_ra];
    end

    always_ff @(posedge aclk) begin
        hash_reg   <= hash_next;
        klen_reg   <= klen_next;
        long_reg   <= long_next;
        get_reg    <= get_next;
        quo_reg    <= quo_next;
        slot_reg   <= slot_next;
        tries_reg  <= tries_next;
        kidx_reg   <= kidx_next;
        vidx_reg   <= vidx_next;
        fresh_reg  <= fresh_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            count_reg   <= '0;
            refused_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            count_reg   <= count_next;
            refused_reg <= refused_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- rtl/core/string_key_hash_map_core.sv -----
// Key/value store for zero-terminated text keys, DJB2 hash with linear probing.
// Key, value and terminator beats are each taken from the queue in the back end's idle
// state; ending a key reaches the home slot through the terminator, a reciprocal multiply
// (S_HMUL), then a multiply-subtract (S_HRED); each probed slot is checked in S_PCHK and
// each compared key byte, terminator included, in S_CMPA and S_CMPB; a get then streams
// its value beats through S_VALA and S_VALB, stalling while the output is held, and a put
// of a new key copies its key, terminator included, through S_COPYA and S_COPYB. The back
// end works on one request at a time; a four-entry command queue lets the input side run
// ahead while it works. Depends on skhm_pkg, skhm_front, skhm_queue, skhm_back.
module string_key_hash_map_core
    import skhm_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int KEY_BYTES   = KEY_BYTES_DEF,
    parameter int VALUE_BYTES = VALUE_BYTES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic push, push_ready, q_valid, q_pop;
    cmd_t push_cmd, q_cmd;

    skhm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    skhm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_cmd    (q_cmd),
        .pop        (q_pop)
    );

    skhm_back #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BYTES   (KEY_BYTES),
        .VALUE_BYTES (VALUE_BYTES)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
